@@ hdl/tgad_pkg.sv @@
// shared constants, codes and types of the tga stream decoder
`default_nettype none
package tgad_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_WIDTH   = 4;
  localparam int PAL_ENTRIES = 256;
  localparam int HDR_BYTES   = 18;

  // image types
  localparam logic [7:0] TYPE_INDEXED     = 8'd1;
  localparam logic [7:0] TYPE_RGB         = 8'd2;
  localparam logic [7:0] TYPE_INDEXED_RLE = 8'd9;
  localparam logic [7:0] TYPE_RGB_RLE     = 8'd10;

  // result kinds
  localparam logic [1:0] KIND_SPAN  = 2'd0;
  localparam logic [1:0] KIND_SIZE  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_SHORT_HDR = 4'd1;
  localparam logic [3:0] ERR_COMMENT   = 4'd2;
  localparam logic [3:0] ERR_TYPE      = 4'd3;
  localparam logic [3:0] ERR_ZERO_SIZE = 4'd4;
  localparam logic [3:0] ERR_CMAP_TYPE = 4'd5;
  localparam logic [3:0] ERR_COLORS    = 4'd6;
  localparam logic [3:0] ERR_CMAP_SIZE = 4'd7;
  localparam logic [3:0] ERR_DEPTH     = 4'd8;
  localparam logic [3:0] ERR_TRUNC     = 4'd9;
  localparam logic [3:0] ERR_SIZE      = 4'd10;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [3:0]  err;
    logic        indexed;
    logic        rle;
    logic        has_pal;
    logic        pal4;
    logic        pix4;
    logic [12:0] width;
    logic [12:0] height;
    logic [8:0]  cm_start;
    logic [8:0]  cm_end;
  } hdr_info_t;

endpackage
`default_nettype wire

@@ hdl/tgad_hdr_check.sv @@
// header decode and validity checks of the tga stream decoder
`default_nettype none
module tgad_hdr_check import tgad_pkg::*; (
  input  wire hdr_bytes_t hdr,
  output hdr_info_t       info
);

  logic [7:0]  img_type;
  logic [15:0] w, h, cm_start, cm_len;
  logic [16:0] cm_sum;
  logic        type_ok, indexed;

  always_comb begin
    img_type = hdr[2];
    w        = {hdr[13], hdr[12]};
    h        = {hdr[15], hdr[14]};
    cm_start = {hdr[4], hdr[3]};
    cm_len   = {hdr[6], hdr[5]};
    cm_sum   = {1'b0, cm_start} + {1'b0, cm_len};
    indexed  = (img_type == TYPE_INDEXED) || (img_type == TYPE_INDEXED_RLE);
    type_ok  = indexed || (img_type == TYPE_RGB) || (img_type == TYPE_RGB_RLE);

    if (!type_ok) begin
      info.err = ERR_TYPE;
    end else if (w == 16'd0 || h == 16'd0) begin
      info.err = ERR_ZERO_SIZE;
    end else if (w < 16'(MIN_WIDTH) || w > 16'(MAX_WIDTH) || h > 16'(MAX_HEIGHT)) begin
      info.err = ERR_SIZE;
    end else if (indexed) begin
      if (hdr[1] != 8'd1) begin
        info.err = ERR_CMAP_TYPE;
      end else if (cm_len > 16'(PAL_ENTRIES)) begin
        info.err = ERR_COLORS;
      end else if (hdr[16] != 8'd8 || hdr[7] < 8'd24) begin
        info.err = ERR_CMAP_SIZE;
      end else if (cm_sum > 17'(PAL_ENTRIES)) begin
        info.err = ERR_COLORS;
      end else begin
        info.err = ERR_NONE;
      end
    end else if (hdr[16] != 8'd24 && hdr[16] != 8'd32) begin
      info.err = ERR_DEPTH;
    end else begin
      info.err = ERR_NONE;
    end

    info.indexed  = indexed;
    info.rle      = (img_type == TYPE_INDEXED_RLE) || (img_type == TYPE_RGB_RLE);
    info.has_pal  = indexed && (cm_len != 16'd0);
    info.pal4     = (hdr[7] == 8'd32);
    info.pix4     = (hdr[16] == 8'd32);
    info.width    = w[12:0];
    info.height   = h[12:0];
    info.cm_start = cm_start[8:0];
    info.cm_end   = cm_sum[8:0];
  end

endmodule
`default_nettype wire

@@ hdl/tga_image_stream_decoder_top.sv @@
// TGA byte stream decoder: takes a file one byte per item, gives RGBA pixel spans
//
// input channel: one file byte per item with an end-of-file mark on the last byte.
// result channel: pixel spans, image size, image complete and error items; the
// last item caused by an input byte carries out_last_result.
// a header, comment or palette byte, and a truecolor pixel byte that completes
// no pixel, is taken without a stall. a byte that causes results holds off the
// input until its results are all loaded into the output register, one result
// at a time, after the palette read of an indexed pixel and before the
// end-of-file check. a run crossing row edges gives one span per row piece.
// a finished result waits in the output register while the next byte is taken.
// the palette lives in a 256 x 32 ram with a write port and a registered read port;
// per-entry valid bits make unwritten entries read as all ones, and they are
// cleared at reset and at the first header byte of each image.
// reset puts the block at the start of a file with no pending result.
// a stalled receiver holds the output register; the block stops only when it has a new result to load.
`default_nettype none
module tga_image_stream_decoder_top import tgad_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_end_of_file,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [23:0] out_start_address,
  output logic [7:0]  out_span_length,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic [3:0]  out_error_code,
  output logic        out_last_result
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_COMMENT = 3'd1;
  localparam logic [2:0] PH_PALETTE = 3'd2;
  localparam logic [2:0] PH_PIXELS  = 3'd3;
  localparam logic [2:0] PH_DRAIN   = 3'd4;

  localparam logic [2:0] ST_IN     = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_PAL_RD = 3'd2;
  localparam logic [2:0] ST_SPAN   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  localparam int PAL_AW = $clog2(PAL_ENTRIES);

  hdr_info_t info;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  hcount_r, hcount_nxt;
  hdr_bytes_t  hdr_r;
  logic [7:0]  comment_r, comment_nxt;
  logic [8:0]  slot_r, slot_nxt;
  logic [2:0][7:0] comp_r, comp_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_run_r, pkt_run_nxt;
  logic [11:0] column_r, column_nxt;
  logic [11:0] row_r, row_nxt;
  logic [23:0] row_base_r, row_base_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] rgba_r, rgba_nxt;
  logic        eof_r, eof_nxt;

  logic [31:0] pal_mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] pal_vld_r;
  logic [31:0] pal_rd_r;
  logic        pal_rd_vld_r;
  logic        pal_we, pal_re, pal_clr, hdr_we;
  logic [PAL_AW-1:0] pal_waddr;
  logic [31:0] pal_wdata;

  logic        out_valid_r, out_load, out_free, acc;
  logic [1:0]  o_kind;
  logic [31:0] o_rgba;
  logic [23:0] o_addr;
  logic [7:0]  o_len;
  logic [12:0] o_w, o_h;
  logic [3:0]  o_err;
  logic        o_last;
  logic [1:0]  out_kind_r;
  logic [31:0] out_rgba_r;
  logic [23:0] out_addr_r;
  logic [7:0]  out_len_r;
  logic [12:0] out_w_r, out_h_r;
  logic [3:0]  out_err_r;
  logic        out_last_r;

  // pixel assembly and span arithmetic
  logic        g_bytes4, g_done;
  logic [31:0] g_rgba;
  logic [11:0] hm1;
  logic [24:0] mul_full;
  logic [12:0] avail, col_sum;
  logic [7:0]  seg, cnt_left;
  logic        row_end;

  tgad_hdr_check u_hdr_check (
    .hdr  (hdr_r),
    .info (info)
  );

  assign acc      = in_valid && (state_r == ST_IN);
  assign in_stall = (state_r != ST_IN);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    g_bytes4 = (phase_r == PH_PALETTE) ? info.pal4 : info.pix4;
    g_done   = g_bytes4 ? (bip_r == 2'd3) : (bip_r == 2'd2);
    g_rgba   = {(bip_r == 2'd3) ? in_data_byte : 8'hff, comp_r[0], comp_r[1],
                (bip_r == 2'd2) ? in_data_byte : comp_r[2]};
    hm1      = 12'(info.height - 13'd1);
    mul_full = 25'(hm1) * 25'(info.width);
    avail    = info.width - {1'b0, column_r};
    seg      = (avail > {5'b0, cnt_r}) ? cnt_r : avail[7:0];
    col_sum  = {1'b0, column_r} + {5'b0, seg};
    row_end  = (col_sum >= info.width);
    cnt_left = cnt_r - seg;
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    hcount_nxt   = hcount_r;
    comment_nxt  = comment_r;
    slot_nxt     = slot_r;
    comp_nxt     = comp_r;
    bip_nxt      = bip_r;
    pkt_left_nxt = pkt_left_r;
    pkt_run_nxt  = pkt_run_r;
    column_nxt   = column_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    cnt_nxt      = cnt_r;
    rgba_nxt     = rgba_r;
    eof_nxt      = eof_r;
    pal_we       = 1'b0;
    pal_re       = 1'b0;
    pal_clr      = 1'b0;
    hdr_we       = 1'b0;
    pal_waddr    = slot_r[PAL_AW-1:0];
    pal_wdata    = g_rgba;
    out_load     = 1'b0;
    o_kind       = KIND_SPAN;
    o_rgba       = 32'd0;
    o_addr       = 24'd0;
    o_len        = 8'd0;
    o_w          = 13'd0;
    o_h          = 13'd0;
    o_err        = ERR_NONE;
    o_last       = 1'b1;

    case (state_r)
      ST_IN: begin
        if (acc) begin
          eof_nxt   = in_end_of_file;
          state_nxt = in_end_of_file ? ST_FIN : ST_IN;
          case (phase_r)
            PH_HEADER: begin
              if (hcount_r == 5'd0) pal_clr = 1'b1;
              hdr_we     = 1'b1;
              hcount_nxt = hcount_r + 5'd1;
              if (hcount_r == 5'(HDR_BYTES - 1)) begin
                comment_nxt = hdr_r[0];
                if (hdr_r[0] != 8'd0) phase_nxt = PH_COMMENT;
                else state_nxt = ST_CHECK;
              end
            end
            PH_COMMENT: begin
              comment_nxt = comment_r - 8'd1;
              if (comment_r == 8'd1) state_nxt = ST_CHECK;
            end
            PH_PALETTE: begin
              if (bip_r != 2'd3) comp_nxt[bip_r] = in_data_byte;
              bip_nxt = g_done ? 2'd0 : bip_r + 2'd1;
              if (g_done) begin
                pal_we   = 1'b1;
                slot_nxt = slot_r + 9'd1;
                if ({1'b0, slot_r} + 10'd1 >= {1'b0, info.cm_end}) begin
                  bip_nxt   = 2'd0;
                  phase_nxt = PH_PIXELS;
                end
              end
            end
            PH_PIXELS: begin
              if (info.rle && pkt_left_r == 8'd0) begin
                // packet header
                pkt_left_nxt = {1'b0, in_data_byte[6:0]} + 8'd1;
                pkt_run_nxt  = in_data_byte[7];
                bip_nxt      = 2'd0;
              end else begin
                cnt_nxt = (info.rle && pkt_run_r) ? pkt_left_r : 8'd1;
                if (info.indexed) begin
                  pal_re    = 1'b1;
                  state_nxt = ST_PAL_RD;
                  if (info.rle) pkt_left_nxt = pkt_run_r ? 8'd0 : pkt_left_r - 8'd1;
                end else begin
                  if (bip_r != 2'd3) comp_nxt[bip_r] = in_data_byte;
                  bip_nxt = g_done ? 2'd0 : bip_r + 2'd1;
                  if (g_done) begin
                    rgba_nxt  = g_rgba;
                    state_nxt = ST_SPAN;
                    if (info.rle) pkt_left_nxt = pkt_run_r ? 8'd0 : pkt_left_r - 8'd1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = eof_r ? ST_FIN : ST_IN;
          if (info.err != ERR_NONE) begin
            o_kind    = KIND_ERROR;
            o_err     = info.err;
            phase_nxt = PH_DRAIN;
          end else begin
            o_kind       = KIND_SIZE;
            o_w          = info.width;
            o_h          = info.height;
            o_last       = !eof_r;
            column_nxt   = 12'd0;
            row_nxt      = hm1;
            row_base_nxt = mul_full[23:0];
            bip_nxt      = 2'd0;
            pkt_left_nxt = 8'd0;
            pkt_run_nxt  = 1'b0;
            slot_nxt     = info.cm_start;
            phase_nxt    = info.has_pal ? PH_PALETTE : PH_PIXELS;
          end
        end
      end
      ST_PAL_RD: begin
        rgba_nxt  = pal_rd_vld_r ? pal_rd_r : 32'hffff_ffff;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_kind     = KIND_SPAN;
          o_rgba     = rgba_r;
          o_addr     = row_base_r + {12'd0, column_r};
          o_len      = seg;
          o_last     = !(row_end && row_r == 12'd0) && cnt_left == 8'd0 && !eof_r;
          cnt_nxt    = cnt_left;
          column_nxt = row_end ? 12'd0 : col_sum[11:0];
          if (row_end && row_r == 12'd0) begin
            phase_nxt = PH_DRAIN;
            state_nxt = ST_DONE;
          end else begin
            if (row_end) begin
              row_nxt      = row_r - 12'd1;
              row_base_nxt = row_base_r - {11'd0, info.width};
            end
            if (cnt_left != 8'd0) state_nxt = ST_SPAN;
            else state_nxt = eof_r ? ST_FIN : ST_IN;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_kind    = KIND_DONE;
          o_w       = info.width;
          o_h       = info.height;
          state_nxt = eof_r ? ST_FIN : ST_IN;
        end
      end
      ST_FIN: begin
        // end of file: report a cut-short image if one is open, then rearm for the next file
        if (phase_r == PH_DRAIN || out_free) begin
          if (phase_r != PH_DRAIN) begin
            out_load = 1'b1;
            o_kind   = KIND_ERROR;
            case (phase_r)
              PH_HEADER:  o_err = ERR_SHORT_HDR;
              PH_COMMENT: o_err = ERR_COMMENT;
              default:    o_err = ERR_TRUNC;
            endcase
          end
          phase_nxt    = PH_HEADER;
          hcount_nxt   = 5'd0;
          comment_nxt  = 8'd0;
          bip_nxt      = 2'd0;
          pkt_left_nxt = 8'd0;
          pkt_run_nxt  = 1'b0;
          state_nxt    = ST_IN;
        end
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      phase_r     <= PH_HEADER;
      hcount_r    <= 5'd0;
      comment_r   <= 8'd0;
      slot_r      <= 9'd0;
      comp_r      <= '0;
      bip_r       <= 2'd0;
      pkt_left_r  <= 8'd0;
      pkt_run_r   <= 1'b0;
      column_r    <= 12'd0;
      row_r       <= 12'd0;
      eof_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pal_vld_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      hcount_r   <= hcount_nxt;
      comment_r  <= comment_nxt;
      slot_r     <= slot_nxt;
      comp_r     <= comp_nxt;
      bip_r      <= bip_nxt;
      pkt_left_r <= pkt_left_nxt;
      pkt_run_r  <= pkt_run_nxt;
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      eof_r      <= eof_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (pal_clr) pal_vld_r <= '0;
      else if (pal_we) pal_vld_r[pal_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    cnt_r      <= cnt_nxt;
    rgba_r     <= rgba_nxt;
    if (hdr_we) hdr_r[hcount_r] <= in_data_byte;
    if (out_load) begin
      out_kind_r <= o_kind;
      out_rgba_r <= o_rgba;
      out_addr_r <= o_addr;
      out_len_r  <= o_len;
      out_w_r    <= o_w;
      out_h_r    <= o_h;
      out_err_r  <= o_err;
      out_last_r <= o_last;
    end
  end

  // palette ram
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
    if (pal_re) begin
      pal_rd_r     <= pal_mem[in_data_byte];
      pal_rd_vld_r <= pal_vld_r[in_data_byte];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_red           = out_rgba_r[7:0];
  assign out_green         = out_rgba_r[15:8];
  assign out_blue          = out_rgba_r[23:16];
  assign out_alpha         = out_rgba_r[31:24];
  assign out_start_address = out_addr_r;
  assign out_span_length   = out_len_r;
  assign out_image_width   = out_w_r;
  assign out_image_height  = out_h_r;
  assign out_error_code    = out_err_r;
  assign out_last_result   = out_last_r;

`ifndef SYNTHESIS
  a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_SPAN |->
      out_span_length != 8'd0 && out_span_length <= 8'd128)
    else $error("span length out of range");

  a_column: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> {1'b0, column_r} < info.width)
    else $error("column past row end");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_ERROR |-> out_last_result)
    else $error("error item not last of its byte");

  a_eof_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_end_of_file |=> state_r != ST_IN || phase_r == PH_HEADER)
    else $error("end of file did not rearm header parse");
`endif

endmodule
`default_nettype wire
